// ===== sv/four_channel_wave_synth_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the four-channel wave synthesiser
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_WAVE_SYNTH_CORE_ASSERT_SVH
`define FOUR_CHANNEL_WAVE_SYNTH_CORE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define FCWS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define FCWS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fcws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcws_pkg
// Types and fixed constants shared by the wave synthesiser controller,
// datapath, top level and checker.
// ----------------------------------------------------------------------------
package fcws_pkg;

    // Request command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Sub-register selected by the two low address bits.
    typedef enum logic [1:0] {
        SUB_FREQ_LO = 2'd0,
        SUB_FREQ_HI = 2'd1,
        SUB_CTRL    = 2'd2,
        SUB_VOLUME  = 2'd3
    } sub_reg_t;

    // Wave shapes held in the control register.
    typedef enum logic [1:0] {
        WAVE_SQUARE   = 2'd0,
        WAVE_SINE     = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_SILENT   = 2'd3
    } wave_kind_t;

    // Wave amplitude in units of 2^-15, plus sign: -32768 .. +32768.
    localparam int WAVE_W = 17;
    localparam logic signed [WAVE_W-1:0] WAVE_POS = 17'sd32768;
    localparam logic signed [WAVE_W-1:0] WAVE_NEG = -17'sd32768;

    // Wave times volume: 17-bit signed by 9-bit signed.
    localparam int PROD_W = 26;

    // Mix scaling: 255 for volume times 4 for the voice share, rounded.
    localparam int RND_DIV      = 1020;
    localparam int RND_HALF     = 510;
    localparam int RND_DIV_BITS = 10;

    // Output saturation limits.
    localparam logic [17:0]        SAT_POS_LIM = 18'd32767;
    localparam logic [17:0]        SAT_NEG_LIM = 18'd32768;
    localparam logic signed [15:0] SAMPLE_MAX  = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN  = 16'sh8000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic reg_write;   // store the request's byte into the voice registers
        logic issue;       // start the next voice down the pipeline
        logic load_out;    // move the mixed sample into the output register
    } fcws_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic issue_last;  // the voice being issued is the final one
        logic result_done; // the rounded mix is ready
    } fcws_status_t;

endpackage

// ===== sv/fcws_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcws_ctrl
// Sequencing state machine: accepts requests, steps the voices through the
// datapath on each tick and hands the mixed sample to the output channel.
// ----------------------------------------------------------------------------
module fcws_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  logic                    command,
    output logic                    sample_valid,
    input  logic                    sample_stall,
    output fcws_pkg::fcws_cmd_t     cmd,
    input  fcws_pkg::fcws_status_t  status
);
    import fcws_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_MIX,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   req_stall_reg, req_stall_next;
    logic   sample_valid_reg, sample_valid_next;
    logic   req_accept;
    logic   out_free;

    assign req_accept = req_valid && !req_stall_reg;
    assign out_free   = !sample_valid_reg || !sample_stall;

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        cmd.reg_write = 1'b0;
        cmd.issue     = 1'b0;
        cmd.load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept && command == CMD_WRITE)
                begin
                    cmd.reg_write = 1'b1;
                end
                if (req_accept && command == CMD_TICK)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (status.issue_last)
                begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                if (status.result_done)
                begin
                    if (out_free)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Registered handshake outputs.
    always_comb
    begin
        req_stall_next    = (state_next != ST_IDLE);
        sample_valid_next = cmd.load_out || (sample_valid_reg && sample_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            req_stall_reg    <= 1'b0;
            sample_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            req_stall_reg    <= req_stall_next;
            sample_valid_reg <= sample_valid_next;
        end
    end

    assign req_stall    = req_stall_reg;
    assign sample_valid = sample_valid_reg;

endmodule

// ===== sv/fcws_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcws_datapath
// Voice register bank and the shared per-voice pipeline: wave generation,
// phase advance, volume scaling, mixing, rounding and the output register.
// ----------------------------------------------------------------------------
module fcws_datapath
#(
    parameter int VOICES           = 4,
    parameter int SAMPLE_RATE      = 48000,
    parameter int SINE_TABLE_DEPTH = 256
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  fcws_pkg::fcws_cmd_t     cmd,
    output fcws_pkg::fcws_status_t  status,
    input  logic [7:0]              reg_addr,
    input  logic [7:0]              write_data,
    output logic signed [15:0]      sample_out
);
    import fcws_pkg::*;

    // Voice index and sine table index widths.
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int KB = $clog2(SINE_TABLE_DEPTH);

    // Reciprocals for the constant divisions by the sample rate.
    // Sine index: floor(P * DEPTH / R) = (P * M_SINE) >> 32.
    localparam logic [63:0] M_SINE =
        ((64'(SINE_TABLE_DEPTH) << 32) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE);
    // Triangle magnitude: floor(X * 32768 / R) = (X * M_TRI) >> 32.
    localparam logic [63:0] M_TRI =
        ((64'd1 << 47) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE);
    localparam int MUL_W = $clog2(M_TRI + 64'd1);
    localparam int WP_W  = 16 + MUL_W;
    // Phase wrap: floor(S / R) = (S * M_PH) >> 33 for a 17-bit sum.
    localparam logic [63:0] M_PH =
        ((64'd1 << 33) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE);
    localparam int PH_W  = $clog2(M_PH + 64'd1);
    localparam int PP_W  = 17 + PH_W;
    localparam int PQ_W  = PP_W - 33;

    // Mix accumulator and rounding division by 1020.
    localparam int A_MAX     = VOICES * 32768 * 255;
    localparam int RND_NB    = $clog2(A_MAX + RND_HALF + 1);
    localparam int ACC_W     = RND_NB + 1;
    localparam int RND_SHIFT = RND_NB + RND_DIV_BITS;
    localparam logic [63:0] M_RND =
        ((64'd1 << RND_SHIFT) + 64'(RND_DIV) - 64'd1) / 64'(RND_DIV);
    localparam int MR_W  = $clog2(M_RND + 64'd1);
    localparam int RP_W  = RND_NB + MR_W;
    localparam int RQ_W  = RP_W - RND_SHIFT;

    // Sine table entry, evaluated at elaboration for each index.
    function automatic logic signed [WAVE_W-1:0] sine_entry(input int unsigned k);
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] t;
        logic [63:0] s;
        begin
            m = 64'(k) * 64'd4;
            q = (m / SINE_TABLE_DEPTH) & 64'd3;
            r = m % SINE_TABLE_DEPTH;
            if (q == 64'd0 || q == 64'd2)
            begin
                u = (r * 64'd32768) / SINE_TABLE_DEPTH;
            end
            else
            begin
                u = ((64'(SINE_TABLE_DEPTH) - r) * 64'd32768) / SINE_TABLE_DEPTH;
            end
            // Odd polynomial in u approximating a quarter sine.
            u2 = (u * u) >> 15;
            t  = (64'd2320 * u2) >> 15;
            t  = 64'd21024 - t;
            t  = (t * u2) >> 15;
            t  = 64'd51472 - t;
            s  = (t * u) >> 15;
            if (q < 64'd2)
            begin
                return WAVE_W'(s);
            end
            else
            begin
                return WAVE_W'(64'd0 - s);
            end
        end
    endfunction

    logic signed [WAVE_W-1:0] sine_rom [SINE_TABLE_DEPTH];

    for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++)
    begin : g_sine_rom
        assign sine_rom[gi] = sine_entry(gi);
    end

    // ------------------------------------------------------------------
    // Voice register bank.
    // ------------------------------------------------------------------
    logic        en_reg    [VOICES];
    wave_kind_t  kind_reg  [VOICES];
    logic [7:0]  vol_reg   [VOICES];
    logic [15:0] freq_reg  [VOICES];
    logic [15:0] phase_reg [VOICES];

    logic          addr_in_range;
    logic [VW-1:0] wr_idx;
    sub_reg_t      wr_sub;

    assign addr_in_range = ({2'b00, reg_addr[7:2]} < 8'(VOICES));
    assign wr_idx        = reg_addr[VW+1:2];
    assign wr_sub        = sub_reg_t'(reg_addr[1:0]);

    // ------------------------------------------------------------------
    // Pipeline registers.
    // ------------------------------------------------------------------
    logic [VW-1:0] issue_cnt_reg;

    logic          s1_vld_reg, s1_first_reg, s1_last_reg, s1_active_reg;
    logic [VW-1:0] s1_voice_reg;
    wave_kind_t    s1_kind_reg;
    logic [7:0]    s1_vol_reg;
    logic          s1_sq_pos_reg, s1_tri_neg_reg;
    logic [15:0]   s1_mul_a_reg;
    logic [16:0]   s1_sum_reg;

    logic          s2_vld_reg, s2_first_reg, s2_last_reg, s2_active_reg;
    logic [VW-1:0] s2_voice_reg;
    wave_kind_t    s2_kind_reg;
    logic [7:0]    s2_vol_reg;
    logic          s2_sq_pos_reg, s2_tri_neg_reg;
    logic [15:0]   s2_quo_reg;
    logic [16:0]   s2_sum_reg;
    logic [PQ_W-1:0] s2_phq_reg;

    logic                     s3_vld_reg, s3_first_reg, s3_last_reg;
    logic signed [WAVE_W-1:0] s3_w_reg;
    logic [7:0]               s3_vol_reg;

    logic                     s4_vld_reg, s4_first_reg, s4_last_reg;
    logic signed [PROD_W-1:0] s4_prod_reg;

    logic signed [ACC_W-1:0]  acc_reg;
    logic                     s5_done_reg;

    logic                     s6_vld_reg, s6_neg_reg;
    logic [RND_NB-1:0]        s6_mag_reg;

    logic                     s7_vld_reg, s7_neg_reg;
    logic [RQ_W-1:0]          s7_q_reg;

    logic signed [15:0]       sample_reg;

    // ------------------------------------------------------------------
    // Stage 1: read the issued voice, shape square and triangle terms.
    // ------------------------------------------------------------------
    logic [15:0] rd_p;
    logic [15:0] rd_f;
    logic        rd_active;
    logic [16:0] twop;
    logic [16:0] rate17;
    logic [16:0] dev;
    logic [17:0] dev2;
    logic [17:0] rate18;
    logic        tri_neg;
    logic [15:0] tri_mag;

    always_comb
    begin
        rd_p      = phase_reg[issue_cnt_reg];
        rd_f      = freq_reg[issue_cnt_reg];
        rd_active = en_reg[issue_cnt_reg] && (rd_f != 16'd0);
        twop      = {rd_p, 1'b0};
        rate17    = 17'(SAMPLE_RATE);
        rate18    = 18'(SAMPLE_RATE);
        dev       = (twop >= rate17) ? (twop - rate17) : (rate17 - twop);
        dev2      = {dev, 1'b0};
        tri_neg   = (dev2 < rate18);
        tri_mag   = tri_neg ? 16'(rate18 - dev2) : 16'(dev2 - rate18);
    end

    // ------------------------------------------------------------------
    // Stage 2: shared wave multiplier and phase wrap quotient.
    // ------------------------------------------------------------------
    logic [MUL_W-1:0] wave_mul_b;
    logic [WP_W-1:0]  wave_prod;
    logic [PP_W-1:0]  ph_prod;

    always_comb
    begin
        wave_mul_b = (s1_kind_reg == WAVE_SINE) ? MUL_W'(M_SINE) : MUL_W'(M_TRI);
        wave_prod  = WP_W'(s1_mul_a_reg) * WP_W'(wave_mul_b);
        ph_prod    = PP_W'(s1_sum_reg) * PP_W'(M_PH);
    end

    // ------------------------------------------------------------------
    // Stage 3: select the wave value, compute the wrapped phase.
    // ------------------------------------------------------------------
    logic signed [WAVE_W-1:0] wave_val;
    logic [16:0]              ph_sub;
    logic [15:0]              new_phase;

    always_comb
    begin
        case (s2_kind_reg)
            WAVE_SQUARE:   wave_val = s2_sq_pos_reg ? WAVE_POS : WAVE_NEG;
            WAVE_SINE:     wave_val = sine_rom[s2_quo_reg[KB-1:0]];
            WAVE_TRIANGLE: wave_val = s2_tri_neg_reg ? -$signed(WAVE_W'(s2_quo_reg))
                                                     : $signed(WAVE_W'(s2_quo_reg));
            WAVE_SILENT:   wave_val = '0;
        endcase
        if (!s2_active_reg)
        begin
            wave_val = '0;
        end
        ph_sub    = 17'(s2_phq_reg) * 17'(SAMPLE_RATE);
        new_phase = 16'(s2_sum_reg - ph_sub);
    end

    // ------------------------------------------------------------------
    // Stage 5 to 7 and output helpers: mix base, magnitude, rounding product, saturation.
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] acc_base;
    logic [ACC_W-1:0]        acc_u;
    logic [ACC_W-1:0]        acc_abs;
    logic [RP_W-1:0]         rnd_prod;
    logic [17:0]             q_ext;
    logic signed [15:0]      sat_val;

    always_comb
    begin
        acc_base = s4_first_reg ? '0 : acc_reg;
        acc_u    = unsigned'(acc_reg);
        acc_abs  = acc_reg[ACC_W-1] ? (~acc_u + 1'b1) : acc_u;
        rnd_prod = RP_W'(s6_mag_reg) * RP_W'(M_RND);
        q_ext    = 18'(s7_q_reg);
        if (s7_neg_reg)
        begin
            sat_val = (q_ext > SAT_NEG_LIM) ? SAMPLE_MIN : $signed(16'(18'd0 - q_ext));
        end
        else
        begin
            sat_val = (q_ext > SAT_POS_LIM) ? SAMPLE_MAX : $signed(16'(q_ext));
        end
    end

    // Voice registers: bus writes while idle, phase write-back during a tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < VOICES; v++)
            begin
                en_reg[v]    <= 1'b0;
                kind_reg[v]  <= WAVE_SQUARE;
                vol_reg[v]   <= 8'd0;
                freq_reg[v]  <= 16'd0;
                phase_reg[v] <= 16'd0;
            end
        end
        else
        begin
            if (cmd.reg_write && addr_in_range)
            begin
                unique case (wr_sub)
                    SUB_FREQ_LO: freq_reg[wr_idx][7:0]  <= write_data;
                    SUB_FREQ_HI: freq_reg[wr_idx][15:8] <= write_data;
                    SUB_CTRL:
                    begin
                        en_reg[wr_idx]   <= write_data[0];
                        kind_reg[wr_idx] <= wave_kind_t'(write_data[2:1]);
                        // Enabling restarts the phase, even if already enabled.
                        if (write_data[0])
                        begin
                            phase_reg[wr_idx] <= 16'd0;
                        end
                    end
                    SUB_VOLUME:  vol_reg[wr_idx] <= write_data;
                    default:     vol_reg[wr_idx] <= vol_reg[wr_idx];
                endcase
            end
            if (s2_vld_reg && s2_active_reg)
            begin
                phase_reg[s2_voice_reg] <= new_phase;
            end
        end
    end

    // Issue counter walks the voices once per tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_cnt_reg <= '0;
        end
        else if (cmd.issue)
        begin
            if (status.issue_last)
            begin
                issue_cnt_reg <= '0;
            end
            else
            begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
            end
        end
    end

    // Pipeline valid and marker bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_done_reg <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= cmd.issue;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_done_reg <= s4_vld_reg && s4_last_reg;
            s6_vld_reg  <= s5_done_reg;
            s7_vld_reg  <= s6_vld_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        // Stage 1.
        s1_first_reg   <= (issue_cnt_reg == '0);
        s1_last_reg    <= status.issue_last;
        s1_voice_reg   <= issue_cnt_reg;
        s1_active_reg  <= rd_active;
        s1_kind_reg    <= kind_reg[issue_cnt_reg];
        s1_vol_reg     <= vol_reg[issue_cnt_reg];
        s1_sq_pos_reg  <= (twop < rate17);
        s1_tri_neg_reg <= tri_neg;
        s1_mul_a_reg   <= (kind_reg[issue_cnt_reg] == WAVE_SINE) ? rd_p : tri_mag;
        s1_sum_reg     <= 17'(rd_p) + 17'(rd_f);

        // Stage 2.
        s2_first_reg   <= s1_first_reg;
        s2_last_reg    <= s1_last_reg;
        s2_voice_reg   <= s1_voice_reg;
        s2_active_reg  <= s1_active_reg;
        s2_kind_reg    <= s1_kind_reg;
        s2_vol_reg     <= s1_vol_reg;
        s2_sq_pos_reg  <= s1_sq_pos_reg;
        s2_tri_neg_reg <= s1_tri_neg_reg;
        s2_quo_reg     <= wave_prod[47:32];
        s2_sum_reg     <= s1_sum_reg;
        s2_phq_reg     <= ph_prod[PP_W-1:33];

        // Stage 3.
        s3_first_reg   <= s2_first_reg;
        s3_last_reg    <= s2_last_reg;
        s3_w_reg       <= wave_val;
        s3_vol_reg     <= s2_vol_reg;

        // Stage 4: volume scaling.
        s4_first_reg   <= s3_first_reg;
        s4_last_reg    <= s3_last_reg;
        s4_prod_reg    <= s3_w_reg * $signed({1'b0, s3_vol_reg});

        // Stage 5: mix accumulation, restarted by the first voice.
        if (s4_vld_reg)
        begin
            acc_reg <= acc_base + ACC_W'(s4_prod_reg);
        end

        // Stage 6: magnitude plus half for rounding.
        if (s5_done_reg)
        begin
            s6_neg_reg <= acc_reg[ACC_W-1];
            s6_mag_reg <= RND_NB'(acc_abs) + RND_NB'(RND_HALF);
        end

        // Stage 7: division by 1020 through the reciprocal.
        if (s6_vld_reg)
        begin
            s7_neg_reg <= s6_neg_reg;
            s7_q_reg   <= rnd_prod[RP_W-1:RND_SHIFT];
        end

        // Output register, saturated.
        if (cmd.load_out)
        begin
            sample_reg <= sat_val;
        end
    end

    assign status.issue_last  = (issue_cnt_reg == VW'(VOICES - 1));
    assign status.result_done = s7_vld_reg;
    assign sample_out         = sample_reg;

endmodule

// ===== sv/four_channel_wave_synth_core.sv =====
`timescale 1ns / 1ps
// Register write request: writes may follow every cycle.
// Tick request: the voices are issued one per cycle into the shared wave
// multiplier pipeline, then the mix is rounded, saturated and loaded; the sample
// becomes valid and the next request can be taken in the same cycle.
// A stalled sample output holds the block after the mix until it is taken.
// rst_n clears all voice registers and phases asynchronously; no clearing pass.
// ----------------------------------------------------------------------------
// four_channel_wave_synth_core
// Multi-voice wave synthesiser: byte-wide register writes set each voice,
// tick requests produce one saturated Q1.15 mixed sample.
// ----------------------------------------------------------------------------
module four_channel_wave_synth_core
#(
    parameter int VOICES           = 4,
    parameter int SAMPLE_RATE      = 48000,
    parameter int SINE_TABLE_DEPTH = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic               command,
    input  logic [7:0]         reg_addr,
    input  logic [7:0]         write_data,
    output logic               sample_valid,
    input  logic               sample_stall,
    output logic signed [15:0] sample_out
);
    import fcws_pkg::*;

    fcws_cmd_t    cmd;
    fcws_status_t status;

    // Sequencer.
    fcws_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .command      (command),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .cmd          (cmd),
        .status       (status)
    );

    // Voice bank and mixing pipeline.
    fcws_datapath
    #(
        .VOICES           (VOICES),
        .SAMPLE_RATE      (SAMPLE_RATE),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .reg_addr   (reg_addr),
        .write_data (write_data),
        .sample_out (sample_out)
    );

endmodule

// ===== sv/fcws_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcws_checker
// Port-level checks of the synthesiser's request and sample channels,
// bound to the top level.
// ----------------------------------------------------------------------------
`include "four_channel_wave_synth_core_assert.svh"

module fcws_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               command,
    input logic               sample_valid,
    input logic               sample_stall,
    input logic signed [15:0] sample_out
);
    import fcws_pkg::*;

    // A register write never holds up the following request.
    `FCWS_ASSERT_NXT(a_write_no_stall, req_valid && !req_stall && command == CMD_WRITE, !req_stall, "write request stalled the next request")

    // A tick request occupies the block on the next cycle.
    `FCWS_ASSERT_NXT(a_tick_busy, req_valid && !req_stall && command == CMD_TICK, req_stall, "tick request did not occupy the block")

    // A new sample only appears at the end of a tick.
    `FCWS_ASSERT_IMP(a_sample_from_tick, $rose(sample_valid), $past(req_stall), "sample appeared without a tick in progress")

    // A stalled sample keeps its value.
    `FCWS_ASSERT_NXT(a_sample_hold, sample_valid && sample_stall, sample_valid && $stable(sample_out), "stalled sample changed")

endmodule

bind four_channel_wave_synth_core fcws_checker u_fcws_checker (.*);

// ===== verif/tb_four_channel_wave_synth_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_channel_wave_synth_core
// Self-checking bench for the four-voice wave synthesiser. A short table of
// directed requests covers reset, full scale, the wave shapes and ignored
// addresses, and random requests follow. The random requests run under several
// idle and stall patterns, the last with one long output hold-off. A local
// model of the voices predicts each mixed sample unless a row types it in.
// ----------------------------------------------------------------------------
module tb_four_channel_wave_synth_core;

    import fcws_pkg::*;

    localparam int NUM_VOICES    = 4;
    localparam int RATE          = 48000;
    localparam int SINE_DEPTH    = 256;
    localparam int DIRECTED_ROWS = 27;
    localparam int SEG_REQUESTS  = 95;
    localparam int HOLDOFF_LEN   = 300;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 200000;

    // One directed request, with a typed-in sample where it is obvious.
    typedef struct packed {
        logic        cmd;
        logic [7:0]  addr;
        logic [7:0]  data;
        logic        known;
        logic [15:0] sample;
    } stim_row_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               req_valid    = 1'b0;
    logic               req_stall;
    logic               command      = CMD_WRITE;
    logic [7:0]         reg_addr     = 8'h00;
    logic [7:0]         write_data   = 8'h00;
    logic               sample_valid;
    logic               sample_stall = 1'b0;
    logic signed [15:0] sample_out;

    // Model of the voice registers.
    logic        voice_on    [NUM_VOICES];
    wave_kind_t  voice_shape [NUM_VOICES];
    logic [7:0]  voice_gain  [NUM_VOICES];
    logic [15:0] voice_freq  [NUM_VOICES];
    logic [15:0] voice_phase [NUM_VOICES];

    logic signed [15:0] pending_samples [$];
    int                 mismatch_count = 0;
    int                 cycle_count    = 0;
    int                 idle_pct       = 0;
    int                 stall_pct      = 0;
    logic               holdoff_go     = 1'b0;
    logic               holdoff_used   = 1'b0;
    int                 holdoff_left   = 0;

    int idle_plan  [5] = '{0, 56, 0, 29, 0};
    int stall_plan [5] = '{0, 0, 56, 29, 0};

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CMD_TICK,  8'h00, 8'h00, 1'b1, 16'd0},     // nothing enabled after reset
        '{CMD_WRITE, 8'h01, 8'h5D, 1'b0, 16'd0},     // voice 0 frequency 0x5D00
        '{CMD_WRITE, 8'h03, 8'hFF, 1'b0, 16'd0},
        '{CMD_WRITE, 8'h02, 8'h01, 1'b0, 16'd0},     // voice 0 square on
        '{CMD_TICK,  8'h00, 8'h00, 1'b1, 16'd8192},  // one voice at full volume
        '{CMD_WRITE, 8'h05, 8'h5D, 1'b0, 16'd0},
        '{CMD_WRITE, 8'h07, 8'hFF, 1'b0, 16'd0},
        '{CMD_WRITE, 8'h06, 8'h01, 1'b0, 16'd0},
        '{CMD_WRITE, 8'h09, 8'h5D, 1'b0, 16'd0},
        '{CMD_WRITE, 8'h0B, 8'hFF, 1'b0, 16'd0},
        '{CMD_WRITE, 8'h0A, 8'h01, 1'b0, 16'd0},
        '{CMD_WRITE, 8'h0D, 8'h5D, 1'b0, 16'd0},
        '{CMD_WRITE, 8'h0F, 8'hFF, 1'b0, 16'd0},
        '{CMD_WRITE, 8'h0E, 8'h01, 1'b0, 16'd0},
        '{CMD_WRITE, 8'h02, 8'h01, 1'b0, 16'd0},     // re-enable clears the phase
        '{CMD_TICK,  8'h00, 8'h00, 1'b1, 16'h7FFF},  // four voices saturate
        '{CMD_WRITE, 8'h02, 8'h03, 1'b0, 16'd0},     // sine
        '{CMD_WRITE, 8'h06, 8'h05, 1'b0, 16'd0},     // triangle
        '{CMD_WRITE, 8'h0A, 8'h07, 1'b0, 16'd0},     // silent shape, still enabled
        '{CMD_WRITE, 8'h0E, 8'hF8, 1'b0, 16'd0},     // off, upper control bits set
        '{CMD_WRITE, 8'h13, 8'hFF, 1'b0, 16'd0},     // beyond the last voice
        '{CMD_WRITE, 8'hFF, 8'hFF, 1'b0, 16'd0},
        '{CMD_WRITE, 8'h00, 8'hFF, 1'b0, 16'd0},
        '{CMD_WRITE, 8'h01, 8'hFF, 1'b0, 16'd0},     // highest frequency
        '{CMD_WRITE, 8'h0B, 8'h00, 1'b0, 16'd0},     // zero volume
        '{CMD_TICK,  8'h00, 8'h00, 1'b0, 16'd0},
        '{CMD_TICK,  8'h00, 8'h00, 1'b0, 16'd0}
    };

    four_channel_wave_synth_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .command      (command),
        .reg_addr     (reg_addr),
        .write_data   (write_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_out   (sample_out)
    );

    // Clock generation.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Sine table entry, built from the polynomial approximation.
    function automatic longint sine_rom(longint k);
        longint m, q, r, u, u2, t, s;
        m = 4 * k;
        q = (m / SINE_DEPTH) % 4;
        r = m % SINE_DEPTH;
        if (q == 0 || q == 2)
            u = (r * 32768) / SINE_DEPTH;
        else
            u = ((SINE_DEPTH - r) * 32768) / SINE_DEPTH;
        u2 = (u * u) >> 15;
        t  = (2320 * u2) >> 15;
        t  = 21024 - t;
        t  = (t * u2) >> 15;
        t  = 51472 - t;
        s  = (t * u) >> 15;
        return (q < 2) ? s : -s;
    endfunction

    // Instantaneous amplitude of one voice at its current phase.
    function automatic longint voice_level(int v);
        longint p, d;
        p = longint'(voice_phase[v]);
        case (voice_shape[v])
            WAVE_SQUARE:
                return (2 * p < RATE) ? 32768 : -32768;
            WAVE_SINE:
                return sine_rom((p * SINE_DEPTH) / RATE);
            WAVE_TRIANGLE:
            begin
                d = 2 * p - RATE;
                if (d < 0)
                    d = -d;
                return ((2 * d - RATE) * 32768) / RATE;
            end
            default:
                return 0;
        endcase
    endfunction

    // Mixes one sample and advances the phase of every active voice.
    function automatic logic signed [15:0] mix_tick();
        longint total, mag, q;
        total = 0;
        for (int v = 0; v < NUM_VOICES; v++)
        begin
            if (!voice_on[v] || voice_freq[v] == 16'd0)
                continue;
            total += voice_level(v) * longint'(voice_gain[v]);
            voice_phase[v] = 16'((longint'(voice_phase[v]) + longint'(voice_freq[v])) % RATE);
        end
        mag = (total < 0) ? -total : total;
        q = (mag + RND_HALF) / RND_DIV;
        if (total < 0)
            q = -q;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return 16'(q);
    endfunction

    // Register write into the voice model; addresses past the voices do nothing.
    function automatic void apply_write(logic [7:0] addr, logic [7:0] data);
        int v;
        v = int'(addr[7:2]);
        if (v < NUM_VOICES)
        begin
            case (sub_reg_t'(addr[1:0]))
                SUB_FREQ_LO: voice_freq[v][7:0]  = data;
                SUB_FREQ_HI: voice_freq[v][15:8] = data;
                SUB_CTRL:
                begin
                    voice_on[v]    = data[0];
                    voice_shape[v] = wave_kind_t'(data[2:1]);
                    if (data[0])
                        voice_phase[v] = 16'd0;
                end
                default:     voice_gain[v] = data;
            endcase
        end
    endfunction

    task automatic note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // Offers one request, waits for it to be taken and records what it should produce.
    task automatic send_request(logic cmd, logic [7:0] addr, logic [7:0] data,
                                logic known, logic [15:0] typed_sample);
        logic signed [15:0] predicted;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        command    <= cmd;
        reg_addr   <= addr;
        write_data <= data;
        do
            @(posedge clk);
        while (req_stall);
        if (cmd == CMD_TICK)
        begin
            predicted = mix_tick();
            pending_samples.push_back(known ? typed_sample : predicted);
        end
        else
            apply_write(addr, data);
    endtask

    // Random request, weighted towards writes to real voices between ticks.
    task automatic random_request(output logic cmd, output logic [7:0] addr,
                                  output logic [7:0] data);
        int roll;
        roll = $urandom_range(0, 99);
        cmd  = (roll < 35) ? CMD_TICK : CMD_WRITE;
        addr = (roll >= 92) ? 8'($urandom_range(16, 255)) : 8'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < 15)
            data = {8{1'($urandom_range(0, 1))}};
        else
            data = 8'($urandom);
    endtask

    // Output side: random stall, with one long hold-off when asked for.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_stall <= 1'b0;
            holdoff_left <= 0;
            holdoff_used <= 1'b0;
        end
        else if (holdoff_go && !holdoff_used)
        begin
            sample_stall <= 1'b1;
            holdoff_left <= HOLDOFF_LEN;
            holdoff_used <= 1'b1;
        end
        else if (holdoff_left > 0)
        begin
            sample_stall <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end
        else
            sample_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Compares each accepted sample with the oldest prediction.
    always @(posedge clk)
    begin
        logic signed [15:0] want;
        if (rst_n && sample_valid && !sample_stall)
        begin
            if (pending_samples.size() == 0)
                note_mismatch($sformatf("unexpected sample %0d", sample_out));
            else
            begin
                want = pending_samples.pop_front();
                if (sample_out !== want)
                    note_mismatch($sformatf("sample expected %0d got %0d", want, sample_out));
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial
    begin
        logic       c;
        logic [7:0] a;
        logic [7:0] d;
        for (int v = 0; v < NUM_VOICES; v++)
        begin
            voice_on[v]    = 1'b0;
            voice_shape[v] = WAVE_SQUARE;
            voice_gain[v]  = 8'd0;
            voice_freq[v]  = 16'd0;
            voice_phase[v] = 16'd0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_request(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].data,
                         directed_rows[i].known, directed_rows[i].sample);

        for (int ph = 0; ph < 5; ph++)
        begin
            idle_pct  = idle_plan[ph];
            stall_pct = stall_plan[ph];
            // The last phase holds the output back so that the block backs up.
            if (ph == 4)
                holdoff_go <= 1'b1;
            repeat (SEG_REQUESTS)
            begin
                random_request(c, a, d);
                send_request(c, a, d, 1'b0, 16'd0);
            end
        end
        req_valid <= 1'b0;

        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
